@@ design/sample_buffer_cache_assert.svh @@
// assertion macros for the sample buffer cache
`ifndef SAMPLE_BUFFER_CACHE_ASSERT_SVH
`define SAMPLE_BUFFER_CACHE_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SBC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// implication with the consequent checked in the next cycle
`define SBC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

@@ design/sbc_pkg.sv @@
// shared types and constants of the sample buffer cache
`default_nettype none
package sbc_pkg;
    localparam logic [1:0] OUT_HIT    = 2'd0;
    localparam logic [1:0] OUT_MISS   = 2'd1;
    localparam logic [1:0] OUT_BYPASS = 2'd2;
    localparam logic [1:0] OUT_TICK   = 2'd3;

    localparam logic [0:0] CFG_RAM_PLAYBACK = 1'd0;
    localparam logic [0:0] CFG_BUFFER_SIZE  = 1'd1;

    localparam logic [29:0] FRESH_AGE = 30'h20000001;
    localparam logic [31:0] DISK_MARK = 32'hff000000;
    localparam logic [31:0] DISK_LOW  = 32'h00ffffff;
    localparam logic [31:0] DISK_BASE = 32'h00140000;
    localparam logic [31:0] EMPTY_TAG = 32'hffffffff;

    // classified command passed from front to back
    typedef struct packed {
        logic        tick;
        logic        bypass;
        logic [31:0] addr;
        logic [31:0] req_end;
        logic [31:0] rebased;
    } cmd_t;

    function automatic logic [31:0] rebase(input logic [31:0] a);
        logic [31:0] r;
        if ((a & DISK_MARK) == DISK_MARK)
            r = (a & DISK_LOW) + DISK_BASE;
        else
            r = a;
        return r;
    endfunction
endpackage
`default_nettype wire

@@ design/sbc_front.sv @@
// front end: accepts commands, classifies them and queues them
`default_nettype none
module sbc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          mode,
    input  wire logic [31:0]   req_addr,
    input  wire logic [15:0]   req_length,
    input  wire logic          ram_playback,
    input  wire logic          pop,
    output logic               busy,
    output logic               cmd_valid,
    output sbc_pkg::cmd_t      cmd
);
    // two-entry queue
    sbc_pkg::cmd_t q_reg [2];
    sbc_pkg::cmd_t q_next0, q_next1, incoming;
    logic [1:0] cnt_reg, cnt_next;
    logic push;

    assign busy = (cnt_reg == 2'd2);
    assign push = start && !busy;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd = q_reg[0];

    always_comb
    begin
        incoming.tick    = mode;
        incoming.bypass  = ram_playback;
        incoming.addr    = req_addr;
        incoming.req_end = req_addr + {16'd0, req_length};
        incoming.rebased = sbc_pkg::rebase(req_addr);
        q_next0 = q_reg[0];
        q_next1 = q_reg[1];
        cnt_next = cnt_reg;
        if (pop && cmd_valid)
        begin
            q_next0 = q_reg[1];
            cnt_next = cnt_next - 2'd1;
        end
        if (push)
        begin
            if (cnt_next == 2'd0)
                q_next0 = incoming;
            else
                q_next1 = incoming;
            cnt_next = cnt_next + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 2'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg[0] <= q_next0;
        q_reg[1] <= q_next1;
    end
endmodule
`default_nettype wire

@@ design/sbc_back.sv @@
// back end: list scan, victim search and list update, one position per cycle
`default_nettype none
module sbc_back #(
    parameter int NUM_BUFFERS = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_valid,
    input  wire sbc_pkg::cmd_t cmd,
    input  wire logic [16:0]   buffer_size,
    output logic               pop,
    output logic               done,
    output logic [1:0]         outcome,
    output logic [2:0]         buffer_index,
    output logic [31:0]        byte_offset,
    output logic [31:0]        fill_addr,
    output logic [31:0]        direct_addr
);
    localparam int IW = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
    localparam int CW = $clog2(NUM_BUFFERS + 1);
    localparam logic [CW-1:0] FULL = CW'(NUM_BUFFERS);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_VICT, S_SHIFT, S_DONE} state_t;

    state_t state_reg;
    logic [31:0]   tag_reg  [NUM_BUFFERS];
    logic [29:0]   age_reg  [NUM_BUFFERS];
    logic [IW-1:0] rank_reg [NUM_BUFFERS];
    logic [CW-1:0] used_reg;
    logic [CW-1:0] pos_reg, ins_reg, vpos_reg;
    logic [IW-1:0] buf_reg;
    logic [29:0]   vage_reg;
    logic [1:0]    outcome_reg;
    logic [2:0]    index_reg;
    logic [31:0]   offset_reg, fill_reg, direct_reg;
    logic          done_reg;

    logic [IW-1:0] cur_buf;
    logic [31:0]   cur_tag, win_end;
    logic [29:0]   cur_age;

    assign cur_buf = rank_reg[pos_reg[IW-1:0]];
    assign cur_tag = tag_reg[cur_buf];
    assign cur_age = age_reg[cur_buf];
    assign win_end = cur_tag + {15'd0, buffer_size};
    assign pop = (state_reg == S_DONE);

    assign done         = done_reg;
    assign outcome      = outcome_reg;
    assign buffer_index = index_reg;
    assign byte_offset  = offset_reg;
    assign fill_addr    = fill_reg;
    assign direct_addr  = direct_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            done_reg  <= 1'b0;
            for (int k = 0; k < NUM_BUFFERS; k++)
            begin
                tag_reg[k] <= sbc_pkg::EMPTY_TAG;
                age_reg[k] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        outcome_reg <= sbc_pkg::OUT_HIT;
                        index_reg   <= '0;
                        offset_reg  <= '0;
                        fill_reg    <= '0;
                        direct_reg  <= '0;
                        pos_reg     <= '0;
                        ins_reg     <= '0;
                        if (cmd.tick)
                        begin
                            for (int k = 0; k < NUM_BUFFERS; k++)
                                if (age_reg[k] != '0)
                                    age_reg[k] <= age_reg[k] - 30'd1;
                            outcome_reg <= sbc_pkg::OUT_TICK;
                            done_reg    <= 1'b1;
                            state_reg   <= S_DONE;
                        end
                        else if (cmd.bypass)
                        begin
                            outcome_reg <= sbc_pkg::OUT_BYPASS;
                            direct_reg  <= cmd.addr;
                            done_reg    <= 1'b1;
                            state_reg   <= S_DONE;
                        end
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (pos_reg >= used_reg || cmd.addr < cur_tag)
                    begin
                        // miss
                        if (used_reg < FULL)
                        begin
                            buf_reg   <= used_reg[IW-1:0];
                            used_reg  <= used_reg + 1'b1;
                            pos_reg   <= used_reg;
                            state_reg <= S_SHIFT;
                        end
                        else
                        begin
                            pos_reg   <= CW'(1);
                            vpos_reg  <= '0;
                            vage_reg  <= age_reg[rank_reg[0]];
                            buf_reg   <= rank_reg[0];
                            state_reg <= S_VICT;
                        end
                    end
                    else if (cmd.req_end <= win_end)
                    begin
                        age_reg[cur_buf] <= sbc_pkg::FRESH_AGE;
                        outcome_reg <= sbc_pkg::OUT_HIT;
                        index_reg   <= 3'(cur_buf);
                        offset_reg  <= cmd.rebased - cur_tag;
                        done_reg    <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                    else
                    begin
                        ins_reg <= pos_reg + 1'b1;
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_VICT:
                begin
                    if (pos_reg >= FULL)
                    begin
                        // remove victim position by shifting the tail down
                        for (int k = 0; k < NUM_BUFFERS - 1; k++)
                            if (CW'(k) >= vpos_reg)
                                rank_reg[k] <= rank_reg[k + 1];
                        if (vpos_reg < ins_reg)
                            ins_reg <= ins_reg - 1'b1;
                        pos_reg   <= FULL - 1'b1;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        if (vage_reg > cur_age)
                        begin
                            vage_reg <= cur_age;
                            vpos_reg <= pos_reg;
                            buf_reg  <= cur_buf;
                        end
                        pos_reg <= pos_reg + 1'b1;
                    end
                end
                S_SHIFT:
                begin
                    // pos_reg walks down from used-1 to ins
                    if (pos_reg > ins_reg)
                    begin
                        rank_reg[pos_reg[IW-1:0]] <= rank_reg[pos_reg[IW-1:0] - 1'b1];
                        pos_reg <= pos_reg - 1'b1;
                    end
                    else
                    begin
                        rank_reg[ins_reg[IW-1:0]] <= buf_reg;
                        tag_reg[buf_reg] <= {cmd.addr[31:1], 1'b0};
                        age_reg[buf_reg] <= sbc_pkg::FRESH_AGE;
                        outcome_reg <= sbc_pkg::OUT_MISS;
                        index_reg   <= 3'(buf_reg);
                        offset_reg  <= cmd.rebased - {cmd.addr[31:1], 1'b0};
                        fill_reg    <= {cmd.addr[31:1], 1'b0};
                        done_reg    <= 1'b1;
                        state_reg   <= S_DONE;
                    end
                end
                S_DONE:
                    state_reg <= S_IDLE;
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ design/sample_buffer_cache.sv @@
// top level of the sample buffer cache
// usage:
//   commands enter on start/mode/req_addr/req_length, taken when start is high
//   and busy is low; a front stage classifies each transaction and queues up
//   to two of them, the back stage executes them one at a time
//   each transaction yields one result, shown for one cycle while done is high
//   ticks and bypass requests finish from the idle state without a list scan
//   hits scan the sorted list up to the matching position; misses also shift
//   the list down from the insertion point and, when full, search every buffer
//   for the victim; these steps in the back stage set the rate
//   configuration writes use cfg_valid/cfg_ready/cfg_index/cfg_data and are
//   always ready; write them only while the block is idle
//   reset empties the list, clears ages, ram_playback=0, buffer_size=1024
//   the receiver cannot stall: results are never held
`default_nettype none
module sample_buffer_cache #(
    parameter int NUM_BUFFERS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [31:0] req_addr,
    input  wire logic [15:0] req_length,
    output logic             done,
    output logic [1:0]       outcome,
    output logic [2:0]       buffer_index,
    output logic [31:0]      byte_offset,
    output logic [31:0]      fill_addr,
    output logic [31:0]      direct_addr,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [16:0] cfg_data
);
`include "sample_buffer_cache_assert.svh"

    logic          ram_playback_reg;
    logic [16:0]   buffer_size_reg;
    logic          cmd_valid, pop;
    sbc_pkg::cmd_t cmd;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_playback_reg <= 1'b0;
            buffer_size_reg  <= 17'd1024;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                sbc_pkg::CFG_RAM_PLAYBACK: ram_playback_reg <= cfg_data[0];
                sbc_pkg::CFG_BUFFER_SIZE:  buffer_size_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // front: accept and classify
    sbc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .mode         (mode),
        .req_addr     (req_addr),
        .req_length   (req_length),
        .ram_playback (ram_playback_reg),
        .pop          (pop),
        .busy         (busy),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd)
    );

    // back: lookup, eviction and list upkeep
    sbc_back #(.NUM_BUFFERS(NUM_BUFFERS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .buffer_size  (buffer_size_reg),
        .pop          (pop),
        .done         (done),
        .outcome      (outcome),
        .buffer_index (buffer_index),
        .byte_offset  (byte_offset),
        .fill_addr    (fill_addr),
        .direct_addr  (direct_addr)
    );

    // a result strobe retires the head of the queue at the same edge
    `SBC_ASSERT_IMP(a_done_pops, clk, rst_n, done, pop, "result without retire")
    // the result strobe lasts a single cycle
    `SBC_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done, "result strobe too long")
    // a hit never reports a fill address
    `SBC_ASSERT_IMP(a_hit_no_fill, clk, rst_n, done && outcome == sbc_pkg::OUT_HIT,
        fill_addr == 32'd0, "fill address on a hit")
    // results appear only for queued work
    `SBC_ASSERT_IMP(a_done_valid, clk, rst_n, done, cmd_valid, "result with empty queue")
endmodule
`default_nettype wire
